// ===== design/pira_pkg.sv =====
package pira_pkg;

	localparam int ACT_W     = 2;
	localparam int POS_W     = 5;
	localparam int DATA_W    = 32;
	localparam int LEN_W     = 6;
	localparam int DEPTH_DEF = 32;

	localparam logic [LEN_W-1:0] LEN_RST = 6'd32;

	// action codes
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// register byte addresses
	localparam logic [2:0] ADDR_LEN = 3'd0;

	typedef struct packed {
		logic        [ACT_W-1:0]  action;
		logic        [POS_W-1:0]  position;
		logic signed [DATA_W-1:0] new_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic                     status;
	} rsp_t;

endpackage

// ===== design/pira_req_if.sv =====
interface pira_req_if;
	logic                                        valid;
	logic                                        ready;
	logic        [pira_pkg::ACT_W-1:0]           action;
	logic        [pira_pkg::POS_W-1:0]           position;
	logic signed [pira_pkg::DATA_W-1:0]          new_value;

	modport source (output valid, output action, output position, output new_value,
		input ready);
	modport sink (input valid, input action, input position, input new_value,
		output ready);
endinterface

// ===== design/pira_rsp_if.sv =====
interface pira_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [pira_pkg::DATA_W-1:0] read_data;
	logic                               status;

	modport source (output valid, output read_data, output status, input ready);
	modport sink (input valid, input read_data, input status, output ready);
endinterface

// ===== design/pira_engine.sv =====
module pira_engine #(
	parameter int DEPTH = pira_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pira_pkg::LEN_W-1:0] cfg_len,
	input  logic                       req_valid,
	input  pira_pkg::req_t             req,
	output logic                       req_ready,
	output logic                       rsp_valid,
	output pira_pkg::rsp_t             rsp,
	input  logic                       rsp_take
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW + 1 > pira_pkg::LEN_W) ? AW + 1 : pira_pkg::LEN_W;
	localparam int XW = (AW > pira_pkg::POS_W) ? AW : pira_pkg::POS_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_RDDATA,
		S_SHR,
		S_SHW,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic        [AW-1:0]               idx_q;
	logic        [AW-1:0]               pos_q;
	logic        [pira_pkg::ACT_W-1:0]  act_q;
	logic signed [pira_pkg::DATA_W-1:0] val_q;
	logic        [CW-1:0]               len_q;
	pira_pkg::rsp_t                     rsp_q;

	logic signed [pira_pkg::DATA_W-1:0] mem [DEPTH];
	logic signed [pira_pkg::DATA_W-1:0] rdata_q;

	logic                               we;
	logic                               re;
	logic        [AW-1:0]               waddr;
	logic        [AW-1:0]               raddr;
	logic signed [pira_pkg::DATA_W-1:0] wdata;

	logic        [CW-1:0]               len_x;
	logic        [CW-1:0]               len_eff;
	logic        [CW-1:0]               len_m1;
	logic        [CW-1:0]               req_pos_c;
	logic        [XW-1:0]               req_pos_x;
	logic        [AW-1:0]               req_pos_a;
	logic        [AW-1:0]               src;
	logic                               more;
	logic                               is_ins;

	// effective length saturates at the array depth
	assign len_x     = CW'(cfg_len);
	assign len_eff   = (len_x > CW'(DEPTH)) ? CW'(DEPTH) : len_x;
	assign len_m1    = len_eff - CW'(1);
	assign req_pos_c = CW'(req.position);
	assign req_pos_x = XW'(req.position);
	assign req_pos_a = req_pos_x[AW-1:0];

	// shared index unit: next source entry and loop end test
	assign is_ins = (act_q == pira_pkg::ACT_INSERT);
	assign src    = is_ins ? (idx_q - AW'(1)) : (idx_q + AW'(1));
	assign more   = is_ins ? (idx_q != pos_q) : ((CW'(idx_q) + CW'(1)) < len_q);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);
	assign rsp       = rsp_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = idx_q;
		raddr = src;
		wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_RD: begin
				re    = 1'b1;
				raddr = pos_q;
			end
			S_SHR: begin
				if (more) begin
					re = 1'b1;
				end else begin
					// insert lands the new word, remove zeroes the last entry
					we    = 1'b1;
					wdata = is_ins ? val_q : '0;
				end
			end
			S_SHW: begin
				we    = 1'b1;
				wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			act_q   <= '0;
			pos_q   <= '0;
			val_q   <= '0;
			len_q   <= '0;
			rsp_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						act_q <= req.action;
						pos_q <= req_pos_a;
						val_q <= req.new_value;
						len_q <= len_eff;
						unique case (req.action)
							pira_pkg::ACT_READ: begin
								if (req_pos_c < len_eff) begin
									state_q <= S_RD;
								end else begin
									rsp_q   <= '{read_data: '0, status: 1'b1};
									state_q <= S_DONE;
								end
							end
							pira_pkg::ACT_INSERT: begin
								if ((req_pos_c + CW'(1)) < len_eff) begin
									idx_q   <= len_m1[AW-1:0];
									state_q <= S_SHR;
								end else begin
									rsp_q   <= '{read_data: '0, status: 1'b1};
									state_q <= S_DONE;
								end
							end
							pira_pkg::ACT_REMOVE: begin
								if (req_pos_c < len_eff) begin
									idx_q   <= req_pos_a;
									state_q <= S_SHR;
								end else begin
									rsp_q   <= '{read_data: '0, status: 1'b1};
									state_q <= S_DONE;
								end
							end
							default: begin
								rsp_q   <= '{read_data: '0, status: 1'b1};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_RDDATA;
				end
				S_RDDATA: begin
					rsp_q   <= '{read_data: rdata_q, status: 1'b0};
					state_q <= S_DONE;
				end
				S_SHR: begin
					if (more) begin
						state_q <= S_SHW;
					end else begin
						rsp_q   <= '{read_data: '0, status: 1'b0};
						state_q <= S_DONE;
					end
				end
				S_SHW: begin
					idx_q   <= src;
					state_q <= S_SHR;
				end
				S_DONE: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/positional_insert_remove_array_core.sv =====
// Positional insert/remove array: DEPTH signed 32-bit entries held in a single-port-write,
// single-port-read memory, all zero after reset, of which the first
// min(length_in_use, DEPTH) take part. A request word reads, inserts or removes at a
// position and always returns one result word; a refused position (or unknown action)
// returns status 1 and leaves the array alone. The work is done by a small sequencer that
// walks the memory one entry at a time, so its memory port sets the rate; a new request
// is taken only once the last result has passed to the output register. An insert or
// remove shifts the entries from its position to the last in use. After reset the
// sequencer first sweeps the memory to zero, while req.ready stays low; configuration
// writes over the APB port are taken at any time. A finished result sits in an output
// register, so the next request can be taken while the consumer still holds off.
module positional_insert_remove_array_core #(
	parameter int DEPTH = pira_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request and result channels
	pira_req_if.sink           req,
	pira_rsp_if.source         rsp
);

	logic [pira_pkg::LEN_W-1:0] len_q;
	logic                       out_valid_q;
	pira_pkg::rsp_t             out_q;

	pira_pkg::req_t             eng_req;
	pira_pkg::rsp_t             eng_rsp;
	logic                       eng_ready;
	logic                       eng_done;
	logic                       eng_take;

	// apb: pready is tied high, the write lands on the access cycle
	assign pready = 1'b1;
	assign prdata = (paddr == pira_pkg::ADDR_LEN) ?
		{{(32 - pira_pkg::LEN_W){1'b0}}, len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= pira_pkg::LEN_RST;
		end else if (psel && penable && pwrite && (paddr == pira_pkg::ADDR_LEN)) begin
			len_q <= pwdata[pira_pkg::LEN_W-1:0];
		end
	end

	// request word into the sequencer
	assign eng_req   = '{action: req.action, position: req.position, new_value: req.new_value};
	assign req.ready = eng_ready;

	pira_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_len   (len_q),
		.req_valid (req.valid),
		.req       (eng_req),
		.req_ready (eng_ready),
		.rsp_valid (eng_done),
		.rsp       (eng_rsp),
		.rsp_take  (eng_take)
	);

	// output register: load a finished result when the slot is free or draining
	assign eng_take = eng_done && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (eng_take) begin
				out_valid_q <= 1'b1;
				out_q       <= eng_rsp;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_q.read_data;
	assign rsp.status    = out_q.status;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import pira_pkg::*;

	// action code the block has no use for, must be refused
	localparam logic [ACT_W-1:0] ACT_SPARE   = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pira_req_if req_ch ();
	pira_rsp_if rsp_ch ();

	positional_insert_remove_array_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// shadow copy of the array and of the length register
	logic signed [DATA_W-1:0] cells [DEPTH_DEF];
	logic [LEN_W-1:0]         len_shadow;

	req_t req_words[$];    // request words waiting to be offered
	rsp_t due_results[$];  // predicted result words, oldest first

	int  req_cnt, rsp_cnt, err_cnt;
	int  n_read, n_insert, n_remove, n_refused, n_settings;
	int  gap_left, stall_left;
	logic calm;      // no idling on either side in the closing stretch
	logic hold_off;  // long receiver hold-off to back the block up

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous overall limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// one request applied to the shadow array; returns the result word it must produce
	function automatic rsp_t array_step(input req_t r);
		rsp_t        o;
		int unsigned lim;
		int unsigned i;
		lim = (len_shadow > DEPTH_DEF) ? DEPTH_DEF : len_shadow;
		o.read_data = '0;
		o.status    = 1'b1;
		case (r.action)
			ACT_READ: begin
				if (r.position < lim) begin
					o.read_data = cells[r.position];
					o.status    = 1'b0;
				end
			end
			ACT_INSERT: begin
				// the last entry in use cannot take an insert
				if (lim >= 1 && r.position < lim - 1) begin
					for (i = lim - 1; i > r.position; i--)
						cells[i] = cells[i-1];
					cells[r.position] = r.new_value;
					o.status = 1'b0;
				end
			end
			ACT_REMOVE: begin
				if (r.position < lim) begin
					for (i = r.position; i + 1 < lim; i++)
						cells[i] = cells[i+1];
					cells[lim-1] = '0;
					o.status = 1'b0;
				end
			end
			default: ;
		endcase
		if (o.status)
			n_refused++;
		else if (r.action == ACT_READ)
			n_read++;
		else if (r.action == ACT_INSERT)
			n_insert++;
		else
			n_remove++;
		return o;
	endfunction

	// request driver: offers queued words, random gaps after accepts
	always @(posedge clk) begin
		req_t taken;
		req_t nxt;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				taken.action    = req_ch.action;
				taken.position  = req_ch.position;
				taken.new_value = req_ch.new_value;
				due_results.push_back(array_step(taken));
				req_cnt++;
				if (!calm && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 15);
			end
			// free to present the next word once the current one is gone
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (req_words.size() > 0) begin
					nxt = req_words.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.action    <= nxt.action;
					req_ch.position  <= nxt.position;
					req_ch.new_value <= nxt.new_value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each accepted word, stalls in random bursts
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_cnt++;
				if (due_results.size() == 0) begin
					flag_mismatch($sformatf("result word with nothing pending: data %0d status %0d",
						rsp_ch.read_data, rsp_ch.status));
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.read_data !== want.read_data)
						flag_mismatch($sformatf("read_data expected %0d got %0d",
							want.read_data, rsp_ch.read_data));
					if (rsp_ch.status !== want.status)
						flag_mismatch($sformatf("status expected %0d got %0d",
							want.status, rsp_ch.status));
				end
			end
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 15);
			end
		end
	end

	// long receiver hold-off while at least 20 request words are still queued,
	// so the output register fills and the block stalls its input
	initial begin
		hold_off = 1'b0;
		while (!(req_cnt >= 60 && req_words.size() >= 20))
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic push_req(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
		input logic [DATA_W-1:0] val);
		req_t r;
		r.action    = act;
		r.position  = pos;
		r.new_value = val;
		req_words.push_back(r);
	endtask

	// mostly well-formed requests in range, with some out of range and spare actions
	function automatic req_t rand_req(input int unsigned lim);
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 6)
			r.action = ACT_INSERT;
		else if (pick < 11)
			r.action = ACT_REMOVE;
		else if (pick < 18)
			r.action = ACT_READ;
		else
			r.action = ACT_SPARE;
		if (lim > 0 && $urandom_range(0, 4) != 0)
			r.position = $urandom_range(0, lim - 1);
		else
			r.position = $urandom_range(0, 31);
		case ($urandom_range(0, 15))
			0: r.new_value = 32'h7fff_ffff;
			1: r.new_value = 32'h8000_0000;
			2: r.new_value = 32'hffff_ffff;
			3: r.new_value = '0;
			default: r.new_value = $urandom;
		endcase
		return r;
	endfunction

	// wait until every offered word has come back, then let the sequencer settle
	task automatic wait_drained;
		while (req_words.size() != 0 || req_ch.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// apb write of length_in_use, then a read back of the same register
	task automatic set_length(input logic [LEN_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_LEN;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		len_shadow = v;
		n_settings++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(v))
			flag_mismatch($sformatf("length_in_use read back expected %0d got %0d", v, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// main sequence
	initial begin
		int unsigned lens [12] = '{2, 32, 7, 45, 1, 0, 19, 32, 63, 12, 3, 33};
		int unsigned lim;
		// all inputs known from time zero
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.action    = '0;
		req_ch.position  = '0;
		req_ch.new_value = '0;
		rsp_ch.ready     = 1'b0;
		calm             = 1'b0;
		gap_left         = 0;
		stall_left       = 0;
		req_cnt          = 0;
		rsp_cnt          = 0;
		err_cnt          = 0;
		n_read           = 0;
		n_insert         = 0;
		n_remove         = 0;
		n_refused        = 0;
		n_settings       = 0;
		len_shadow       = LEN_RST;
		for (int k = 0; k < DEPTH_DEF; k++)
			cells[k] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset length: array edges, signed extremes,
		// the refused insert at the last entry and the spare action
		push_req(ACT_READ,   5'd0,  32'h0);
		push_req(ACT_READ,   5'd31, 32'h0);
		push_req(ACT_INSERT, 5'd0,  32'h7fff_ffff);
		push_req(ACT_INSERT, 5'd0,  32'h8000_0000);
		push_req(ACT_INSERT, 5'd30, 32'hffff_ffff);
		push_req(ACT_INSERT, 5'd31, 32'h1234_5678);
		push_req(ACT_READ,   5'd30, 32'h0);
		push_req(ACT_READ,   5'd31, 32'h0);
		push_req(ACT_REMOVE, 5'd31, 32'h0);
		push_req(ACT_REMOVE, 5'd0,  32'hffff_ffff);
		push_req(ACT_SPARE,  5'd31, 32'hffff_ffff);
		push_req(ACT_READ,   5'd0,  32'h0);
		push_req(ACT_INSERT, 5'd15, 32'h5555_5555);
		push_req(ACT_INSERT, 5'd16, 32'haaaa_aaaa);
		push_req(ACT_READ,   5'd15, 32'h0);
		wait_drained();

		// zero length: everything refused
		set_length(6'd0);
		push_req(ACT_READ,   5'd0, 32'h0);
		push_req(ACT_INSERT, 5'd0, 32'h0000_0001);
		push_req(ACT_REMOVE, 5'd0, 32'h0);
		wait_drained();

		// single entry: no insert possible, read and remove of entry 0 only
		set_length(6'd1);
		push_req(ACT_INSERT, 5'd0, 32'h0000_0002);
		push_req(ACT_READ,   5'd0, 32'h0);
		push_req(ACT_REMOVE, 5'd0, 32'h0);
		push_req(ACT_READ,   5'd1, 32'h0);
		wait_drained();

		// length above depth saturates
		set_length(6'd63);
		push_req(ACT_INSERT, 5'd30, 32'hdead_beef);
		push_req(ACT_READ,   5'd31, 32'h0);
		push_req(ACT_REMOVE, 5'd31, 32'h0);
		wait_drained();

		// random phases over a spread of lengths, closing one without idling
		foreach (lens[p]) begin
			if (p == $size(lens) - 1)
				calm = 1'b1;
			set_length(lens[p][LEN_W-1:0]);
			lim = (lens[p] > DEPTH_DEF) ? DEPTH_DEF : lens[p];
			repeat (38)
				req_words.push_back(rand_req(lim));
			wait_drained();
		end

		// longest request is an insert or remove at position 0
		repeat (2 * DEPTH_DEF + 8) @(posedge clk);

		$display("covered %0d request words: %0d reads, %0d inserts, %0d removes, %0d refused",
			req_cnt, n_read, n_insert, n_remove, n_refused);
		$display("%0d result words checked over %0d length settings, %0d mismatches",
			rsp_cnt, n_settings, err_cnt);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
